// File: src/ccat_pkg.sv
// Package with shared types and constants for the cell charge accumulator.
package ccat_pkg;

  localparam int unsigned TableCellsDefault = 32;
  localparam int unsigned IdW = 64;
  localparam int unsigned SumW = 40;
  localparam int unsigned DepW = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ChargeW = 31;
  localparam int unsigned DropW = 16;

  localparam logic CmdAccumulate = 1'b0;
  localparam logic CmdFlush = 1'b1;
  localparam logic KindCell = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [DropW-1:0] DropMax = {DropW{1'b1}};
  localparam logic [ChargeW-1:0] ChargeMax = {ChargeW{1'b1}};

  typedef struct packed {
    logic                    command;
    logic [IdW-1:0]          cell_id;
    logic [DepW-1:0]         energy_deposit;
    logic signed [TimeW-1:0] time_stamp;
  } hit_t;

  typedef struct packed {
    logic                    kind;
    logic [IdW-1:0]          out_cell_id;
    logic [ChargeW-1:0]      charge;
    logic signed [TimeW-1:0] earliest_time;
    logic [DropW-1:0]        dropped_hits;
    logic                    last;
  } result_t;

  // Rounds a sum of 1/256 keV units half up to keV and saturates.
  function automatic logic [ChargeW-1:0] to_charge(input logic [SumW-1:0] s);
    logic [SumW:0] q;
    q = ({1'b0, s} + (SumW+1)'(128)) >> 8;
    if (q > (SumW+1)'(ChargeMax)) return ChargeMax;
    return q[ChargeW-1:0];
  endfunction

endpackage

// File: src/ccat_if.sv
// Valid/ready stream interface carrying one payload type.
interface ccat_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/ccat_table.sv
// Cell table memory: key, sum and time arrays with registered read.
module ccat_table #(
  parameter int unsigned TableCells = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                         clk,
  input  logic [AddrW-1:0]             rd_addr,
  output logic [ccat_pkg::IdW-1:0]     rd_key,
  output logic [ccat_pkg::SumW-1:0]    rd_sum,
  output logic [ccat_pkg::TimeW-1:0]   rd_time,
  input  logic                         wr_en,
  input  logic                         wr_key_en,
  input  logic [AddrW-1:0]             wr_addr,
  input  logic [ccat_pkg::IdW-1:0]     wr_key,
  input  logic [ccat_pkg::SumW-1:0]    wr_sum,
  input  logic [ccat_pkg::TimeW-1:0]   wr_time
);
  import ccat_pkg::*;

  logic [IdW-1:0]   keys_mem  [TableCells];
  logic [SumW-1:0]  sums_mem  [TableCells];
  logic [TimeW-1:0] times_mem [TableCells];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums_mem[wr_addr]  <= wr_sum;
      times_mem[wr_addr] <= wr_time;
      if (wr_key_en) keys_mem[wr_addr] <= wr_key;
    end
    rd_key  <= keys_mem[rd_addr];
    rd_sum  <= sums_mem[rd_addr];
    rd_time <= times_mem[rd_addr];
  end
endmodule

// File: src/cell_charge_accumulate_threshold.sv
// Top level of the cell charge accumulator with threshold readout.
// An accumulate transaction checks stored entries in order, each with a read state
// (S_SCAN) then a compare state (S_CHECK); it ends on a match, on an empty table, or at
// the fill count with an insert or a drop. One transaction is in flight at a time.
// A flush walks the entries likewise, stalling while the output register waits on ready.
// Reset (synchronous, rst_n low) clears fill count, drop count, threshold and control.
module cell_charge_accumulate_threshold #(
  parameter int unsigned TABLE_CELLS = ccat_pkg::TableCellsDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ccat_if.sink                           in_ch,
  ccat_if.source                         out_ch,
  input  logic                           cfg_we,
  input  logic [ccat_pkg::SumW-1:0]      cfg_wdata
);
  import ccat_pkg::*;

  localparam int unsigned AddrW = (TABLE_CELLS > 1) ? $clog2(TABLE_CELLS) : 1;
  localparam int unsigned CntW = $clog2(TABLE_CELLS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHECK, S_FLUSH, S_FCHECK, S_SUMMARY}
    state_t;

  state_t            state_r;
  logic [CntW-1:0]   fill_r;
  logic [DropW-1:0]  drop_r;
  logic [SumW-1:0]   thr_r;
  logic [CntW-1:0]   idx_r;
  hit_t              hit_r;
  logic              out_valid_r;
  result_t           out_r;

  logic [AddrW-1:0]  rd_addr;
  logic [IdW-1:0]    rd_key;
  logic [SumW-1:0]   rd_sum;
  logic [TimeW-1:0]  rd_time;
  logic              wr_en, wr_key_en;
  logic [AddrW-1:0]  wr_addr;
  logic [SumW-1:0]   wr_sum;
  logic [TimeW-1:0]  wr_time;
  logic [SumW:0]     sum_add;
  logic              out_free;
  logic              out_load;

  ccat_table #(.TableCells(TABLE_CELLS), .AddrW(AddrW)) u_table (
    .clk, .rd_addr, .rd_key, .rd_sum, .rd_time,
    .wr_en, .wr_key_en, .wr_addr, .wr_key(hit_r.cell_id), .wr_sum, .wr_time
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = out_free &&
                    ((state_r == S_FCHECK && rd_sum >= thr_r) || state_r == S_SUMMARY);
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;
  assign rd_addr = idx_r[AddrW-1:0];
  assign sum_add = {1'b0, rd_sum} + (SumW+1)'(hit_r.energy_deposit);

  // Write-back: merge on a key match, insert when the scan ends.
  always_comb begin
    wr_en = 1'b0;
    wr_key_en = 1'b0;
    wr_addr = idx_r[AddrW-1:0];
    wr_sum = SumW'(hit_r.energy_deposit);
    wr_time = hit_r.time_stamp;
    if (state_r == S_CHECK && rd_key == hit_r.cell_id) begin
      wr_en = 1'b1;
      wr_sum = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
      wr_time = ($signed(hit_r.time_stamp) < $signed(rd_time)) ? hit_r.time_stamp : rd_time;
    end else if (state_r == S_SCAN && idx_r == fill_r && fill_r < CntW'(TABLE_CELLS)) begin
      wr_en = 1'b1;
      wr_key_en = 1'b1;
    end
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      drop_r <= '0;
      thr_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (in_ch.valid) begin
            hit_r <= in_ch.data;
            state_r <= (in_ch.data.command == CmdFlush) ? S_FLUSH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r == fill_r) begin
            if (fill_r < CntW'(TABLE_CELLS)) fill_r <= fill_r + 1'b1;
            else if (drop_r != DropMax) drop_r <= drop_r + 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_key == hit_r.cell_id) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_FLUSH: begin
          state_r <= (idx_r == fill_r) ? S_SUMMARY : S_FCHECK;
        end
        S_FCHECK: begin
          if (rd_sum < thr_r) begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_FLUSH;
          end else if (out_free) begin
            out_r <= '{kind: KindCell, out_cell_id: rd_key, charge: to_charge(rd_sum),
                       earliest_time: rd_time, dropped_hits: '0, last: 1'b0};
            idx_r <= idx_r + 1'b1;
            state_r <= S_FLUSH;
          end
        end
        S_SUMMARY: begin
          if (out_free) begin
            out_r <= '{kind: KindSummary, out_cell_id: '0, charge: '0,
                       earliest_time: '0, dropped_hits: drop_r, last: 1'b1};
            fill_r <= '0;
            drop_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The fill count never exceeds the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(TABLE_CELLS)) else $error("fill count beyond table");
  // A summary clears the counters.
  a_summary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUMMARY && out_free) |=> (fill_r == '0 && drop_r == '0))
    else $error("counters not cleared after summary");
  // Scan index stays within the stored entries.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r <= fill_r)) else $error("index past fill");
  // A summary result always carries last.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last == (out_r.kind == KindSummary)))
    else $error("last mismatch");
endmodule
